// ===== hw/rtl/fgr_pkg.sv =====
// Shared constants and the job record for the font glyph column renderer.
// No dependencies; imported by every module of the block.
package fgr_pkg;

  localparam int FONT_BYTES      = 4096;
  localparam int FONT_AW         = $clog2(FONT_BYTES);
  localparam int MAX_GLYPH_WIDTH = 16;
  localparam int MAX_PAGES       = 4;
  localparam int RESULT_LIMIT    = 64;
  localparam int QUEUE_DEPTH     = 2;
  localparam int PAGE_W          = 4;  // holds up to fifteen pages

  // header byte offsets
  localparam logic [2:0] HDR_LEN_HI = 3'd0;
  localparam logic [2:0] HDR_LEN_LO = 3'd1;
  localparam logic [2:0] HDR_WIDTH  = 3'd2;
  localparam logic [2:0] HDR_HEIGHT = 3'd3;
  localparam logic [2:0] HDR_FIRST  = 3'd4;
  localparam logic [2:0] HDR_COUNT  = 3'd5;
  localparam logic [2:0] HDR_TABLE  = 3'd6;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_DRAW  = 1'b1;

  // one classified draw, handed from front to back
  typedef struct packed {
    logic               single;  // one result only, no store reads
    logic               err;
    logic [15:0]        ox;
    logic [15:0]        oy;
    logic [15:0]        color;
    logic [7:0]         width;
    logic [PAGE_W-1:0]  pages;
    logic [FONT_AW-1:0] base;
  } job_t;

endpackage

// ===== hw/rtl/fgr_font_store.sv =====
// Font image store: one write port, two registered read ports.
// Depends on fgr_pkg for the store size.
module fgr_font_store (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [fgr_pkg::FONT_AW-1:0] wr_addr,
  input  logic [7:0]                 wr_data,
  input  logic [fgr_pkg::FONT_AW-1:0] ra_addr,
  output logic [7:0]                 ra_data,
  input  logic [fgr_pkg::FONT_AW-1:0] rb_addr,
  output logic [7:0]                 rb_data
);
  import fgr_pkg::*;

  logic [7:0] mem [FONT_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

// ===== hw/rtl/fgr_front.sv =====
// Front end: accepts words, performs store writes, reads the header and walks
// the width table, then queues one classified job per draw. Uses fgr_pkg.
module fgr_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        func,
  input  logic [11:0]                 font_addr,
  input  logic [7:0]                  font_byte,
  input  logic signed [15:0]          origin_x,
  input  logic signed [15:0]          origin_y,
  input  logic [7:0]                  char_code,
  input  logic [15:0]                 ink_color,
  input  logic                        back_idle,
  output logic                        wr_en,
  output logic [fgr_pkg::FONT_AW-1:0] wr_addr,
  output logic [7:0]                  wr_data,
  output logic [fgr_pkg::FONT_AW-1:0] rd_addr,
  input  logic [7:0]                  rd_data,
  output logic                        push,
  output fgr_pkg::job_t               push_job,
  input  logic                        q_ready
);
  import fgr_pkg::*;

  typedef enum logic [7:0] {
    F_IDLE  = 8'b0000_0001,
    F_WRITE = 8'b0000_0010,
    F_HDR   = 8'b0000_0100,
    F_CLASS = 8'b0000_1000,
    F_WALK  = 8'b0001_0000,
    F_CALC  = 8'b0010_0000,
    F_BASE  = 8'b0100_0000,
    F_PUSH  = 8'b1000_0000
  } fstate_t;

  fstate_t state;

  logic [FONT_AW-1:0] wa;
  logic [7:0]         wd;
  logic [15:0]        ox, oy, color;
  logic [7:0]         ch;
  logic [7:0]         len_hi, len_lo, fixed_w, height, first_ch, count;
  logic [2:0]         hcnt;
  logic [2:0]         hdr_sel;
  logic [7:0]         idx;
  logic [5:0]         pages;
  logic [5:0]         pages_c;
  logic [7:0]         width;
  logic [11:0]        sum;
  logic [7:0]         wcnt;
  logic [13:0]        wp;
  logic               is_fixed;
  job_t               job;

  logic               out_of_range;
  logic [13:0]        mul_a;
  logic [7:0]         mul_b;
  logic [21:0]        prod;
  logic [FONT_AW-1:0] base_c;
  logic               too_big;
  logic               empty_glyph;

  assign in_ready = (state == F_IDLE);
  assign wr_en    = (state == F_WRITE) && back_idle;
  assign wr_addr  = wa;
  assign wr_data  = wd;
  assign push     = (state == F_PUSH) && q_ready;
  assign push_job = job;
  assign hdr_sel  = hcnt - 3'd1;

  always_comb begin
    case (state)
      F_HDR:   rd_addr = FONT_AW'(hcnt);
      F_WALK:  rd_addr = FONT_AW'(HDR_TABLE) + FONT_AW'(wcnt);
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    out_of_range = (ch < CHAR_SPACE) || (ch > CHAR_TILDE) || (ch < first_ch) ||
                   ((ch - first_ch) >= count);
    pages_c      = 6'((9'(height) + 9'd7) >> 3);
    // fixed: idx * (pages * width); table: sum * pages, both modulo the store
    mul_a        = is_fixed ? wp : 14'(sum);
    mul_b        = is_fixed ? idx : 8'(pages);
    prod         = 22'(mul_a) * 22'(mul_b);
    base_c       = FONT_AW'(prod) + (is_fixed ? FONT_AW'(0) : FONT_AW'(count)) +
                   FONT_AW'(HDR_TABLE);
    too_big      = (width > 8'(MAX_GLYPH_WIDTH)) || (pages > 6'(MAX_PAGES)) ||
                   (wp > 14'(RESULT_LIMIT));
    empty_glyph  = (width == 8'd0) || (pages == 6'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            wa    <= FONT_AW'(font_addr);
            wd    <= font_byte;
            ox    <= origin_x;
            oy    <= origin_y;
            ch    <= char_code;
            color <= ink_color;
            hcnt  <= 3'd0;
            state <= (func == FUNC_WRITE) ? F_WRITE : F_HDR;
          end
        end
        F_WRITE: begin
          if (back_idle) begin
            state <= F_IDLE;
          end
        end
        F_HDR: begin
          hcnt <= hcnt + 3'd1;
          if (hcnt != 3'd0) begin
            case (hdr_sel)
              HDR_LEN_HI: len_hi   <= rd_data;
              HDR_LEN_LO: len_lo   <= rd_data;
              HDR_WIDTH:  fixed_w  <= rd_data;
              HDR_HEIGHT: height   <= rd_data;
              HDR_FIRST:  first_ch <= rd_data;
              HDR_COUNT:  count    <= rd_data;
              default: ;
            endcase
          end
          if (hcnt == HDR_TABLE) begin
            state <= F_CLASS;
          end
        end
        F_CLASS: begin
          idx      <= ch - first_ch;
          pages    <= pages_c;
          is_fixed <= (len_hi == 8'd0) && (len_lo == 8'd0);
          sum      <= '0;
          wcnt     <= '0;
          width    <= fixed_w;
          if (out_of_range) begin
            job   <= '{single: 1'b1, err: 1'b0, ox: ox, oy: oy, color: color,
                       width: 8'd0, pages: '0, base: '0};
            state <= F_PUSH;
          end else if ((len_hi == 8'd0) && (len_lo == 8'd0)) begin
            state <= F_CALC;
          end else begin
            state <= F_WALK;
          end
        end
        F_WALK: begin
          // read for entry wcnt goes out now, data of entry wcnt-1 is back
          wcnt <= wcnt + 8'd1;
          if (wcnt != 8'd0) begin
            if ((wcnt - 8'd1) < idx) begin
              sum <= sum + 12'(rd_data);
            end else begin
              width <= rd_data;
              state <= F_CALC;
            end
          end
        end
        F_CALC: begin
          wp    <= 14'(width) * 14'(pages);
          state <= F_BASE;
        end
        F_BASE: begin
          job   <= '{single: too_big || empty_glyph, err: too_big, ox: ox, oy: oy,
                     color: color, width: width, pages: PAGE_W'(pages), base: base_c};
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (q_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/fgr_queue.sv =====
// Short job queue between the front and back ends.
// Uses fgr_pkg for the job record.
module fgr_queue #(
  parameter int DEPTH = fgr_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fgr_pkg::job_t push_job,
  output logic          q_ready,
  output logic          q_valid,
  output fgr_pkg::job_t q_job,
  input  logic          pop
);
  import fgr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign q_ready = (count != CW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != CW'(DEPTH)) || pop)
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("job popped from empty queue");

endmodule

// ===== hw/rtl/fgr_back.sv =====
// Back end: takes queued jobs, reads glyph bytes page by page and column by
// column, and holds each result word in the output register. Uses fgr_pkg.
module fgr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  fgr_pkg::job_t               q_job,
  output logic                        pop,
  output logic                        back_idle,
  output logic [fgr_pkg::FONT_AW-1:0] rb_addr,
  input  logic [7:0]                  rb_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [15:0]          col_x,
  output logic signed [15:0]          page_y,
  output logic [7:0]                  pixel_mask,
  output logic [15:0]                 color_out,
  output logic [7:0]                  glyph_width,
  output logic                        last,
  output logic                        error
);
  import fgr_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_LOAD = 3'b010,
    B_SHOW = 3'b100
  } bstate_t;

  bstate_t            state;
  job_t               job;
  logic [7:0]         col;
  logic [PAGE_W-1:0]  page;
  logic [FONT_AW-1:0] ptr, ptr_next;

  assign pop       = (state == B_IDLE) && q_valid;
  assign back_idle = (state == B_IDLE) && !q_valid;
  // store address is the pointer's next value, so data is ready in B_LOAD
  assign rb_addr   = ptr_next;

  always_comb begin
    ptr_next = ptr;
    if ((state == B_IDLE) && q_valid) begin
      ptr_next = q_job.base;
    end else if ((state == B_SHOW) && out_ready && !last) begin
      ptr_next = ptr + FONT_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            job  <= q_job;
            col  <= '0;
            page <= '0;
            ptr  <= ptr_next;
            if (q_job.single) begin
              col_x       <= q_job.ox;
              page_y      <= q_job.oy;
              pixel_mask  <= 8'd0;
              color_out   <= q_job.color;
              glyph_width <= q_job.width;
              last        <= 1'b1;
              error       <= q_job.err;
              out_valid   <= 1'b1;
              state       <= B_SHOW;
            end else begin
              state <= B_LOAD;
            end
          end
        end
        B_LOAD: begin
          col_x       <= job.ox + 16'(col);
          page_y      <= job.oy + 16'({page, 3'b000});
          pixel_mask  <= rb_data;
          color_out   <= job.color;
          glyph_width <= job.width;
          last        <= (col == job.width - 8'd1) && (page == job.pages - PAGE_W'(1));
          error       <= 1'b0;
          out_valid   <= 1'b1;
          state       <= B_SHOW;
        end
        B_SHOW: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= B_IDLE;
            end else begin
              ptr <= ptr_next;
              if (col == job.width - 8'd1) begin
                col  <= '0;
                page <= page + PAGE_W'(1);
              end else begin
                col <= col + 8'd1;
              end
              state <= B_LOAD;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> last && (pixel_mask == 8'd0))
    else $error("error word not a lone empty last word");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> (state == B_IDLE) && !out_valid)
    else $error("back end did not finish after last word");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    pop |-> !out_valid)
    else $error("job taken while a word is still pending");

endmodule

// ===== hw/rtl/font_glyph_column_renderer_core.sv =====
// Top level of the font glyph column renderer: front end, job queue, back end
// and font store. Depends on fgr_pkg and the fgr_* modules.
//
// A write word (func 0) stores one font byte and is held back while the back
// end is still emitting results of earlier draws, since a store write waits
// until every queued draw has read its glyph. A draw word (func 1) passes in
// the front end through the header reads, classification and base reckoning;
// a character outside the font skips the reckoning, and a proportional font
// adds the walk over the width table through one store read port, one entry
// per cycle, up to the character's index; a full queue adds its wait on top.
// The back end picks up a job, then reads each glyph column byte from the
// store and holds it in the output register, width times pages bytes in all,
// or a single result word for an empty or flagged result. The queue of
// QUEUE_DEPTH jobs lets the front end classify the next character while the
// back end is still emitting. The font store is not cleared by reset; a glyph
// must only refer to bytes written.
module font_glyph_column_renderer_core #(
  parameter int QUEUE_DEPTH = fgr_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [11:0]        font_addr,
  input  logic [7:0]         font_byte,
  input  logic signed [15:0] origin_x,
  input  logic signed [15:0] origin_y,
  input  logic [7:0]         char_code,
  input  logic [15:0]        ink_color,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] col_x,
  output logic signed [15:0] page_y,
  output logic [7:0]         pixel_mask,
  output logic [15:0]        color_out,
  output logic [7:0]         glyph_width,
  output logic               last,
  output logic               error
);
  import fgr_pkg::*;

  logic               wr_en;
  logic [FONT_AW-1:0] wr_addr;
  logic [7:0]         wr_data;
  logic [FONT_AW-1:0] ra_addr, rb_addr;
  logic [7:0]         ra_data, rb_data;
  logic               push, q_ready, q_valid, pop, back_idle;
  job_t               push_job, q_job;

  fgr_font_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .ra_addr (ra_addr),
    .ra_data (ra_data),
    .rb_addr (rb_addr),
    .rb_data (rb_data)
  );

  fgr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .font_addr (font_addr),
    .font_byte (font_byte),
    .origin_x  (origin_x),
    .origin_y  (origin_y),
    .char_code (char_code),
    .ink_color (ink_color),
    .back_idle (back_idle),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (ra_addr),
    .rd_data   (ra_data),
    .push      (push),
    .push_job  (push_job),
    .q_ready   (q_ready)
  );

  fgr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .pop      (pop)
  );

  fgr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_job       (q_job),
    .pop         (pop),
    .back_idle   (back_idle),
    .rb_addr     (rb_addr),
    .rb_data     (rb_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .col_x       (col_x),
    .page_y      (page_y),
    .pixel_mask  (pixel_mask),
    .color_out   (color_out),
    .glyph_width (glyph_width),
    .last        (last),
    .error       (error)
  );

endmodule

// ===== test/fgr_column_checker.sv =====
// Column-word checker for the font glyph column renderer: mirrors the font
// store, predicts the words of every draw and compares them in order.
// Depends on fgr_pkg only; sits beside the block and watches both channels.
module fgr_column_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        func,
  input  logic [11:0] font_addr,
  input  logic [7:0]  font_byte,
  input  logic [15:0] origin_x,
  input  logic [15:0] origin_y,
  input  logic [7:0]  char_code,
  input  logic [15:0] ink_color,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] col_x,
  input  logic [15:0] page_y,
  input  logic [7:0]  pixel_mask,
  input  logic [15:0] color_out,
  input  logic [7:0]  glyph_width,
  input  logic        last,
  input  logic        error,
  output int          failures,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import fgr_pkg::*;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  mask;
    logic [15:0] color;
    logic [7:0]  width;
    logic        last_col;
    logic        flagged;
  } column_word_t;

  column_word_t       expected_cols[$];
  logic [7:0]         font_mem [FONT_BYTES];
  int                 mismatch_count = 0;
  int                 queued_cols = 0;

  assign failures    = mismatch_count;
  assign outstanding = queued_cols;

  function automatic int unsigned font_rd(input int unsigned a);
    return font_mem[a % FONT_BYTES];
  endfunction

  task automatic push_col(input logic [15:0] x, input logic [15:0] y,
                          input logic [7:0] mask, input logic [15:0] color,
                          input logic [7:0] width, input logic last_col,
                          input logic flagged);
    column_word_t c;
    c = '{x, y, mask, color, width, last_col, flagged};
    expected_cols.push_back(c);
  endtask

  // glyph lookup: fixed width by multiply, proportional by summing widths
  task automatic predict_draw(input logic [15:0] ox, input logic [15:0] oy,
                              input logic [7:0] ch, input logic [15:0] color);
    int unsigned first, count, idx, height, pages, width, base;
    first = font_rd(HDR_FIRST);
    count = font_rd(HDR_COUNT);
    if (ch < CHAR_SPACE || ch > CHAR_TILDE || ch < first || ch - first >= count) begin
      push_col(ox, oy, 8'h00, color, 8'h00, 1'b1, 1'b0);
      return;
    end
    idx    = ch - first;
    height = font_rd(HDR_HEIGHT);
    pages  = (height + 7) / 8;
    if (font_rd(HDR_LEN_HI) == 0 && font_rd(HDR_LEN_LO) == 0) begin
      width = font_rd(HDR_WIDTH);
      base  = idx * (pages * width) + HDR_TABLE;
    end else begin
      base = 0;
      for (int unsigned i = 0; i < idx; i++) base += font_rd(HDR_TABLE + i);
      base  = base * pages + count + HDR_TABLE;
      width = font_rd(HDR_TABLE + idx);
    end
    if (width > MAX_GLYPH_WIDTH || pages > MAX_PAGES || width * pages > RESULT_LIMIT) begin
      push_col(ox, oy, 8'h00, color, 8'(width), 1'b1, 1'b1);
      return;
    end
    if (width == 0 || pages == 0) begin
      push_col(ox, oy, 8'h00, color, 8'(width), 1'b1, 1'b0);
      return;
    end
    // page by page, columns left to right; a partial last page is not masked
    for (int unsigned h = 0; h < pages; h++)
      for (int unsigned w = 0; w < width; w++)
        push_col(16'(ox + w), 16'(oy + 8 * h), 8'(font_rd(base + h * width + w)),
                 color, 8'(width), (h + 1 == pages) && (w + 1 == width), 1'b0);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    column_word_t want;
    if (rst) begin
      expected_cols.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (func == FUNC_WRITE) font_mem[font_addr] = font_byte;
        else predict_draw(origin_x, origin_y, char_code, ink_color);
      end
      if (out_valid && out_ready) begin
        if (expected_cols.size() == 0) begin
          $error("column word with nothing expected: col_x 0x%0h page_y 0x%0h",
                 col_x, page_y);
          mismatch_count++;
        end else begin
          want = expected_cols.pop_front();
          check_field("col_x", want.x, col_x);
          check_field("page_y", want.y, page_y);
          check_field("pixel_mask", want.mask, pixel_mask);
          check_field("color_out", want.color, color_out);
          check_field("glyph_width", want.width, glyph_width);
          check_field("last", want.last_col, last);
          check_field("error", want.flagged, error);
        end
      end
    end
    queued_cols <= expected_cols.size();
  end

endmodule

// ===== test/tb_font_glyph_column_renderer_core.sv =====
// Testbench top for font_glyph_column_renderer_core: writes a series of small
// font layouts and draws characters from them with random idling.
// Depends on fgr_pkg, the RTL and fgr_column_checker.
module tb_font_glyph_column_renderer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import fgr_pkg::*;

  // longest quiet stretch of a correct run: a long sender gap plus a full
  // width-table walk, or a long receiver stall; taken several times over
  localparam int IDLE_LIMIT = 4000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               func = FUNC_WRITE;
  logic [11:0]        font_addr = '0;
  logic [7:0]         font_byte = '0;
  logic signed [15:0] origin_x = '0;
  logic signed [15:0] origin_y = '0;
  logic [7:0]         char_code = '0;
  logic [15:0]        ink_color = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] col_x;
  logic signed [15:0] page_y;
  logic [7:0]         pixel_mask;
  logic [15:0]        color_out;
  logic [7:0]         glyph_width;
  logic               last;
  logic               error;

  int failures;
  int outstanding;
  int idle_cycles = 0;
  int rx_stall = 0;
  bit steady_tx = 1'b0;
  bit steady_rx = 1'b0;
  int draws_sent = 0;
  int writes_sent = 0;
  int font_first = 0;
  int font_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  font_glyph_column_renderer_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .font_addr  (font_addr),
    .font_byte  (font_byte),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .char_code  (char_code),
    .ink_color  (ink_color),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .col_x      (col_x),
    .page_y     (page_y),
    .pixel_mask (pixel_mask),
    .color_out  (color_out),
    .glyph_width(glyph_width),
    .last       (last),
    .error      (error)
  );

  fgr_column_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .font_addr  (font_addr),
    .font_byte  (font_byte),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .char_code  (char_code),
    .ink_color  (ink_color),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .col_x      (col_x),
    .page_y     (page_y),
    .pixel_mask (pixel_mask),
    .color_out  (color_out),
    .glyph_width(glyph_width),
    .last       (last),
    .error      (error),
    .failures   (failures),
    .outstanding(outstanding)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic [15:0] pick_word16();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'h8000;
    if (r < 8) return 16'h7FFF;
    if (r < 11) return 16'h7FF8;
    if (r < 13) return 16'hFFFF;
    if (r < 15) return 16'h0000;
    return 16'($urandom);
  endfunction

  // mostly a character the current font holds, else any code at all
  function automatic logic [7:0] pick_char();
    int lo, hi;
    lo = (font_first > int'(CHAR_SPACE)) ? font_first : int'(CHAR_SPACE);
    hi = font_first + font_count - 1;
    if (hi > int'(CHAR_TILDE)) hi = int'(CHAR_TILDE);
    if (lo <= hi && $urandom_range(0, 99) < 80) return 8'($urandom_range(lo, hi));
    return 8'($urandom);
  endfunction

  task automatic send_word(input logic f, input logic [11:0] a, input logic [7:0] b,
                           input logic [15:0] ox, input logic [15:0] oy,
                           input logic [7:0] ch, input logic [15:0] color);
    int gap;
    gap = steady_tx ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    font_addr <= a;
    font_byte <= b;
    origin_x  <= ox;
    origin_y  <= oy;
    char_code <= ch;
    ink_color <= color;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_byte(input logic [11:0] a, input logic [7:0] b);
    send_word(FUNC_WRITE, a, b, 16'($urandom), 16'($urandom), 8'($urandom),
              16'($urandom));
    writes_sent++;
  endtask

  // consecutive store bytes with random contents
  task automatic write_run(input int start, input int n);
    for (int i = 0; i < n; i++) write_byte(12'(start + i), 8'($urandom));
  endtask

  task automatic draw_char(input logic [7:0] ch, input logic [15:0] ox,
                           input logic [15:0] oy, input logic [15:0] color);
    send_word(FUNC_DRAW, 12'($urandom), 8'($urandom), ox, oy, ch, color);
    draws_sent++;
  endtask

  always @(posedge clk) begin
    if (rx_stall > 0) begin
      rx_stall--;
      out_ready <= 1'b0;
    end else if (steady_rx || $urandom_range(0, 3) != 0) begin
      out_ready <= 1'b1;
    end else begin
      rx_stall = gap_len();
      out_ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // every byte a draw reads is written first
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fixed width 2, one page, characters 'A' to 'D' at bytes 6 to 13
    write_byte(12'(HDR_LEN_HI), 8'h00);
    write_byte(12'(HDR_LEN_LO), 8'h00);
    write_byte(12'(HDR_WIDTH), 8'd2);
    write_byte(12'(HDR_HEIGHT), 8'd8);
    write_byte(12'(HDR_FIRST), "A");
    write_byte(12'(HDR_COUNT), 8'd4);
    write_run(int'(HDR_TABLE), 8);
    draw_char("A", 16'h0000, 16'h0000, 16'hFFFF);
    draw_char("B", 16'h7FFF, 16'h7FF8, 16'h0000);
    draw_char("C", 16'hFFFF, 16'h8000, 16'hA5A5);
    draw_char("D", 16'h8000, 16'hFFFF, 16'h5A5A);
    draw_char(CHAR_SPACE - 8'd1, 16'h1234, 16'h8000, 16'hA5A5);
    draw_char(CHAR_TILDE + 8'd1, 16'h8000, 16'h7FFF, 16'h5A5A);
    draw_char(8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    draw_char(8'hFF, 16'h0000, 16'h0000, 16'h0000);
    draw_char("@", 16'h0010, 16'h0020, 16'h0F0F);
    draw_char("E", 16'h0010, 16'h0020, 16'h0F0F);

    // width 3, height 9: partial second page, glyphs at bytes 6 to 17
    write_byte(12'(HDR_WIDTH), 8'd3);
    write_byte(12'(HDR_HEIGHT), 8'd9);
    write_byte(12'(HDR_COUNT), 8'd2);
    write_run(14, 4);
    draw_char("A", 16'h7FFE, 16'h7FFC, 16'hCAFE);
    draw_char("B", 16'hFFFE, 16'hFFF8, 16'hBEEF);
    draw_char("C", 16'h0040, 16'h0050, 16'hCAFE);

    // too wide, too many pages, far too tall
    write_byte(12'(HDR_WIDTH), 8'(MAX_GLYPH_WIDTH + 1));
    draw_char("A", 16'h0001, 16'h0002, 16'h0003);
    write_byte(12'(HDR_WIDTH), 8'd4);
    write_byte(12'(HDR_HEIGHT), 8'(8 * MAX_PAGES + 1));
    draw_char("B", 16'h0004, 16'h0005, 16'h0006);
    write_byte(12'(HDR_HEIGHT), 8'd255);
    draw_char("A", 16'hFFF0, 16'hFFF0, 16'h0007);
    // empty glyphs: zero width, zero height
    write_byte(12'(HDR_WIDTH), 8'd0);
    write_byte(12'(HDR_HEIGHT), 8'd8);
    draw_char("B", 16'h0100, 16'h0200, 16'h0300);
    write_byte(12'(HDR_WIDTH), 8'd5);
    write_byte(12'(HDR_HEIGHT), 8'd0);
    draw_char("A", 16'h0100, 16'h0200, 16'h0300);

    // no characters at all, then a range that starts below the space
    write_byte(12'(HDR_COUNT), 8'd0);
    draw_char("A", 16'h0000, 16'h0000, 16'h0001);
    write_byte(12'(HDR_FIRST), 8'h1E);
    write_byte(12'(HDR_COUNT), 8'd4);
    draw_char(8'h1F, 16'h0011, 16'h0022, 16'h0033);
    draw_char(CHAR_SPACE, 16'h0011, 16'h0022, 16'h0033);
    draw_char(8'h22, 16'h0011, 16'h0022, 16'h0033);

    // proportional, 'A' to 'R': 'A' to 'P' too wide, 'R' empty, and the
    // widths before 'Q' add up so that its glyph wraps past the store end
    write_byte(12'(HDR_LEN_HI), 8'h01);
    write_byte(12'(HDR_HEIGHT), 8'd8);
    write_byte(12'(HDR_FIRST), "A");
    write_byte(12'(HDR_COUNT), 8'd18);
    for (int i = 0; i < 18; i++)
      write_byte(12'(int'(HDR_TABLE) + i),
                 (i < 15) ? 8'd255 : (i == 15) ? 8'd245 : (i == 16) ? 8'd3 : 8'd0);
    write_byte(12'(FONT_BYTES - 2), 8'($urandom));
    write_byte(12'(FONT_BYTES - 1), 8'($urandom));
    draw_char("A", 16'h0300, 16'h0400, 16'h00FF);
    draw_char("P", 16'h0300, 16'h0400, 16'h00FF);
    draw_char("Q", 16'h7FFE, 16'h0400, 16'hFF00);
    draw_char("R", 16'h0300, 16'h0400, 16'h00FF);

    // back to fixed width 2, fresh glyph bytes, then random draws
    write_byte(12'(HDR_LEN_HI), 8'h00);
    write_byte(12'(HDR_WIDTH), 8'd2);
    write_byte(12'(HDR_HEIGHT), 8'd8);
    write_byte(12'(HDR_COUNT), 8'd4);
    write_run(int'(HDR_TABLE), 8);
    font_first = int'("A");
    font_count = 4;
    for (int p = 0; p < 3; p++) begin
      steady_tx = (p == 1);
      steady_rx <= (p == 2);
      for (int i = 0; i < 6; i++) begin
        if ($urandom_range(0, 99) < 15)
          write_byte(12'($urandom_range(int'(HDR_TABLE), int'(HDR_TABLE) + 7)),
                     8'($urandom));
        else
          draw_char(pick_char(), pick_word16(), pick_word16(), pick_word16());
      end
    end
    steady_tx = 1'b0;
    in_valid <= 1'b0;
    steady_rx <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Drew %0d characters with %0d font byte writes: fixed and proportional",
             draws_sent, writes_sent);
    $display("glyphs, empty, flagged and out-of-range ones, wrapping, random stalls.");
    if (failures == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
